// File: rtl/tsi_pkg.sv
package tsi_pkg;

  // field and register widths
  localparam int PRICE_W = 32;
  localparam int OUT_W   = 24;
  localparam int PER_W   = 11;
  localparam int WARM_W  = 10;
  localparam int BAR_W   = 13;
  localparam int IDX_W   = 2;

  // internal value, weight and arithmetic lane widths
  localparam int VAL_W = 48;
  localparam int K_W   = 24;
  localparam int ACC_W = 60;
  localparam int REM_W = 49;
  localparam int CNT_W = 6;

  localparam int unsigned MAX_PERIOD = 1024;
  localparam logic [BAR_W-1:0] BAR_MAX   = '1;
  localparam logic [OUT_W-1:0] OUT_LIMIT = 24'd6553600;

  // iteration counts of the serial lanes
  localparam logic [CNT_W-1:0] ITER_WEIGHT = 6'd25;
  localparam logic [CNT_W-1:0] ITER_SEED   = 6'd43;
  localparam logic [CNT_W-1:0] ITER_MUL    = 6'd24;
  localparam logic [CNT_W-1:0] ITER_FINAL  = 6'd23;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_FIRST_PERIOD  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SECOND_PERIOD = 2'd1;
  localparam logic [IDX_W-1:0] REG_EXTRA_WARMUP  = 2'd2;

  typedef enum logic [2:0] {
    OP_WEIGHT,
    OP_SEED1,
    OP_EMA1,
    OP_SEED2,
    OP_EMA2,
    OP_FINAL
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic             prime;
    logic             load;
    logic             acc1;
    logic             acc2;
    logic             start;
    op_e              op;
    logic             publish;
    logic [PER_W-1:0] n1;
    logic [PER_W-1:0] n2;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
  } dp_stat_t;

  // one request to a serial multiply / divide lane
  typedef struct packed {
    logic             start;
    logic             is_mul;
    logic [CNT_W-1:0] iters;
    logic [ACC_W-1:0] acc_init;
    logic [REM_W-1:0] rem_init;
    logic [VAL_W-1:0] opnd;
  } lane_req_t;

endpackage

// File: rtl/tsi_lane.sv
module tsi_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tsi_pkg::lane_req_t        req_i,
  output logic                      done_o,
  output logic [tsi_pkg::ACC_W-1:0] result_o
);
  import tsi_pkg::*;

  logic             busy_q, done_q, mul_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] opnd_q;
  logic [REM_W-1:0] trial;
  logic             fits;

  // one shift-add or restoring-divide step per cycle
  always_comb begin
    trial = {rem_q[REM_W-2:0], acc_q[ACC_W-1]};
    fits  = trial >= {1'b0, opnd_q};
    if (mul_q) begin
      acc_d = {acc_q[ACC_W-2:0], 1'b0} + (rem_q[REM_W-1] ? ACC_W'(opnd_q) : '0);
      rem_d = {rem_q[REM_W-2:0], 1'b0};
    end else begin
      acc_d = {acc_q[ACC_W-2:0], fits};
      rem_d = fits ? trial - {1'b0, opnd_q} : trial;
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mul_q  <= req_i.is_mul;
      acc_q  <= req_i.acc_init;
      rem_q  <= req_i.rem_init;
      opnd_q <= req_i.opnd;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("lane reports done while still iterating");
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("lane started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> cnt_q != 0)
    else $error("lane iteration count ran out while busy");

endmodule

// File: rtl/tsi_dp.sv
module tsi_dp (
  input  logic                        clk_i,
  input  tsi_pkg::dp_cmd_t            cmd_i,
  output tsi_pkg::dp_stat_t           stat_o,
  input  logic [tsi_pkg::PRICE_W-1:0] price_i,
  output logic [tsi_pkg::OUT_W-1:0]   tsi_value_o,
  input  logic                        rst_ni
);
  import tsi_pkg::*;

  logic [PRICE_W-1:0] prev_q;
  logic [VAL_W-1:0]   mom_q, mag_q, mom_d;
  logic [VAL_W-1:0]   seed1_q [2];
  logic [VAL_W-1:0]   ema1_q  [2];
  logic [VAL_W-1:0]   seed2_q [2];
  logic [VAL_W-1:0]   ema2_q  [2];
  logic [VAL_W-1:0]   chain_x [2];
  logic [K_W-1:0]     k1_q, k2_q;
  logic [OUT_W-1:0]   out_q;
  op_e                op_q;
  logic [1:0]         neg_q, neg_d;
  logic               ovf_q;
  lane_req_t          req [2];
  logic [1:0]         done;
  logic [ACC_W-1:0]   res [2];
  logic [VAL_W-1:0]   num_abs;
  logic [36:0]        fin_a;
  logic [ACC_W-1:0]   fin_b, fin_d;
  logic               fin_ovf, den_pos;

  function automatic logic [VAL_W-1:0] abs48(logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? -v : v;
  endfunction

  // ema plus floor(product / 2^24)
  function automatic logic [VAL_W-1:0] ema_upd(logic [VAL_W-1:0] ema,
                                               logic [ACC_W-1:0] p, logic n);
    logic [ACC_W-1:0] r;
    logic [VAL_W-1:0] m;
    r = n ? p + ACC_W'(24'hFFFFFF) : p;
    m = {12'b0, r[ACC_W-1:24]};
    return n ? ema - m : ema + m;
  endfunction

  assign chain_x[0] = mom_q;
  assign chain_x[1] = mag_q;
  assign mom_d      = {16'b0, price_i} - {16'b0, prev_q};

  // scaled numerator for the final quotient: |num| * 6553600
  assign num_abs = abs48(ema2_q[0]);
  assign fin_a   = num_abs[36:0];
  assign fin_b   = {23'b0, fin_a};
  assign fin_d   = (fin_b << 22) + (fin_b << 21) + (fin_b << 18);
  assign fin_ovf = {11'b0, fin_d[ACC_W-1:23]} >= ema2_q[1];
  assign den_pos = !ema2_q[1][VAL_W-1] && (ema2_q[1] != '0);

  // operand set-up, lane 0 signed chain, lane 1 magnitude chain
  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_comb begin
      logic [PER_W:0]   d;
      logic [25:0]      dv;
      logic [VAL_W-1:0] mg;
      logic [VAL_W:0]   df;
      d  = (l == 0) ? {1'b0, cmd_i.n1} + 1'b1 : {1'b0, cmd_i.n2} + 1'b1;
      dv = 26'h2000000 + 26'(d >> 1);
      mg = '0;
      df = '0;
      req[l].start    = cmd_i.start;
      req[l].is_mul   = 1'b0;
      req[l].iters    = ITER_WEIGHT;
      req[l].acc_init = '0;
      req[l].rem_init = '0;
      req[l].opnd     = '0;
      neg_d[l]        = 1'b0;
      case (cmd_i.op)
        OP_WEIGHT: begin
          req[l].acc_init = {dv[24:0], 35'b0};
          req[l].rem_init = REM_W'(dv[25]);
          req[l].opnd     = VAL_W'(d);
        end
        OP_SEED1, OP_SEED2: begin
          mg = (cmd_i.op == OP_SEED1) ? seed1_q[l] : seed2_q[l];
          neg_d[l] = mg[VAL_W-1];
          mg = abs48(mg);
          req[l].iters    = ITER_SEED;
          req[l].acc_init = {mg[42:0], 17'b0};
          req[l].opnd     = (cmd_i.op == OP_SEED1) ? VAL_W'(cmd_i.n1) : VAL_W'(cmd_i.n2);
        end
        OP_EMA1, OP_EMA2: begin
          if (cmd_i.op == OP_EMA1) begin
            df = {chain_x[l][VAL_W-1], chain_x[l]} - {ema1_q[l][VAL_W-1], ema1_q[l]};
            req[l].rem_init = {k1_q, 25'b0};
          end else begin
            df = {ema1_q[l][VAL_W-1], ema1_q[l]} - {ema2_q[l][VAL_W-1], ema2_q[l]};
            req[l].rem_init = {k2_q, 25'b0};
          end
          neg_d[l] = df[VAL_W];
          df = df[VAL_W] ? -df : df;
          req[l].is_mul = 1'b1;
          req[l].iters  = ITER_MUL;
          req[l].opnd   = df[VAL_W-1:0];
        end
        OP_FINAL: begin
          neg_d[l] = ema2_q[0][VAL_W-1];
          req[l].iters    = ITER_FINAL;
          req[l].acc_init = {fin_d[22:0], 37'b0};
          req[l].rem_init = {12'b0, fin_d[ACC_W-1:23]};
          req[l].opnd     = ema2_q[1];
        end
        default: ;
      endcase
    end

    tsi_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .req_i   (req[l]),
      .done_o  (done[l]),
      .result_o(res[l])
    );
  end

  assign stat_o.done = done[0];

  // chain state, weights and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      mom_q  <= '0;
      mag_q  <= '0;
      k1_q   <= '0;
      k2_q   <= '0;
      op_q   <= OP_WEIGHT;
      neg_q  <= '0;
      ovf_q  <= 1'b0;
      out_q  <= '0;
      for (int i = 0; i < 2; i++) begin
        seed1_q[i] <= '0;
        ema1_q[i]  <= '0;
        seed2_q[i] <= '0;
        ema2_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.prime) prev_q <= price_i;
      if (cmd_i.load) begin
        prev_q <= price_i;
        mom_q  <= mom_d;
        mag_q  <= abs48(mom_d);
      end
      if (cmd_i.start) begin
        op_q  <= cmd_i.op;
        neg_q <= neg_d;
        ovf_q <= fin_ovf;
      end
      for (int i = 0; i < 2; i++) begin
        if (cmd_i.acc1) seed1_q[i] <= seed1_q[i] + chain_x[i];
        if (cmd_i.acc2) seed2_q[i] <= seed2_q[i] + ema1_q[i];
        if (done[0]) begin
          case (op_q)
            OP_SEED1: ema1_q[i] <= neg_q[i] ? -res[i][VAL_W-1:0] : res[i][VAL_W-1:0];
            OP_SEED2: ema2_q[i] <= neg_q[i] ? -res[i][VAL_W-1:0] : res[i][VAL_W-1:0];
            OP_EMA1:  ema1_q[i] <= ema_upd(ema1_q[i], res[i], neg_q[i]);
            OP_EMA2:  ema2_q[i] <= ema_upd(ema2_q[i], res[i], neg_q[i]);
            default: ;
          endcase
        end
      end
      if (done[0] && op_q == OP_WEIGHT) begin
        k1_q <= res[0][K_W-1:0];
        k2_q <= res[1][K_W-1:0];
      end
      // zero for a non-positive denominator, else clamp and sign of the final quotient
      if (cmd_i.publish) begin
        if (!den_pos) begin
          out_q <= '0;
        end else if (ovf_q || {1'b0, res[0][22:0]} > OUT_LIMIT) begin
          out_q <= neg_q[0] ? -OUT_LIMIT : OUT_LIMIT;
        end else begin
          out_q <= neg_q[0] ? -{1'b0, res[0][22:0]} : {1'b0, res[0][22:0]};
        end
      end
    end
  end

  assign tsi_value_o = out_q;

endmodule

// File: rtl/tsi_ctrl.sv
module tsi_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tsi_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [tsi_pkg::PER_W-1:0] cfg_data_i,
  input  logic                      s_valid_i,
  output logic                      s_ready_o,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output tsi_pkg::dp_cmd_t          cmd_o,
  input  tsi_pkg::dp_stat_t         stat_i
);
  import tsi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WGT, S_WGT_WAIT, S_ST1, S_SEED1, S_W1,
    S_ST2, S_SEED2, S_W2, S_END, S_WF, S_PUB
  } state_e;

  state_e            state_q;
  logic [PER_W-1:0]  n1_q, n2_q, n1c, n2c;
  logic [WARM_W-1:0] u_q;
  logic              wt_pend_q, primed_q, out_valid_q;
  logic [BAR_W-1:0]  bar_q, j;
  logic [PER_W:0]    l1, l2;
  logic              in1, seed1_now, in2, j_lt, seed2_now, emit, accept, out_free;

  // effective periods and warm-up boundaries
  always_comb begin
    n1c = (n1_q < 2) ? PER_W'(2) : (n1_q > PER_W'(MAX_PERIOD)) ? PER_W'(MAX_PERIOD) : n1_q;
    n2c = (n2_q < 2) ? PER_W'(2) : (n2_q > PER_W'(MAX_PERIOD)) ? PER_W'(MAX_PERIOD) : n2_q;
    l1  = {1'b0, n1c} - 1'b1 + (PER_W+1)'(u_q);
    l2  = {1'b0, n2c} - 1'b1 + (PER_W+1)'(u_q);
    in1       = bar_q < BAR_W'(n1c);
    seed1_now = bar_q == BAR_W'(n1c) - 1'b1;
    in2       = bar_q >= BAR_W'(l1);
    j         = bar_q - BAR_W'(l1);
    j_lt      = j < BAR_W'(n2c);
    seed2_now = j == BAR_W'(n2c) - 1'b1;
    emit      = bar_q >= BAR_W'(l1) + BAR_W'(l2);
  end

  assign s_ready_o = (state_q == S_IDLE) && !wt_pend_q;
  assign accept    = s_ready_o && s_valid_i;
  assign out_free  = !out_valid_q || m_ready_i;
  assign m_valid_o = out_valid_q;

  // datapath commands
  always_comb begin
    cmd_o    = '0;
    cmd_o.n1 = n1c;
    cmd_o.n2 = n2c;
    cmd_o.op = OP_WEIGHT;
    case (state_q)
      S_IDLE: begin
        cmd_o.prime = accept && !primed_q;
        cmd_o.load  = accept && primed_q;
      end
      S_WGT: cmd_o.start = 1'b1;
      S_ST1: begin
        if (in1) begin
          cmd_o.acc1 = 1'b1;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_EMA1;
        end
      end
      S_SEED1: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_SEED1;
      end
      S_ST2: begin
        if (in2 && j_lt) begin
          cmd_o.acc2 = 1'b1;
        end else if (in2) begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_EMA2;
        end
      end
      S_SEED2: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_SEED2;
      end
      S_END: begin
        cmd_o.start = emit;
        cmd_o.op    = OP_FINAL;
      end
      S_PUB: cmd_o.publish = out_free;
      default: ;
    endcase
  end

  // sequencer, configuration registers and output word flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n1_q        <= PER_W'(25);
      n2_q        <= PER_W'(13);
      u_q         <= '0;
      wt_pend_q   <= 1'b1;
      primed_q    <= 1'b0;
      bar_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FIRST_PERIOD:  n1_q <= cfg_data_i;
          REG_SECOND_PERIOD: n2_q <= cfg_data_i;
          REG_EXTRA_WARMUP:  u_q  <= cfg_data_i[WARM_W-1:0];
          default: ;
        endcase
        wt_pend_q <= 1'b1;
      end else if (state_q == S_WGT) begin
        wt_pend_q <= 1'b0;
      end

      out_valid_q <= cmd_o.publish || (out_valid_q && !m_ready_i);

      case (state_q)
        S_IDLE: begin
          if (wt_pend_q) begin
            state_q <= S_WGT;
          end else if (accept) begin
            primed_q <= 1'b1;
            if (primed_q) state_q <= S_ST1;
          end
        end
        S_WGT:      state_q <= S_WGT_WAIT;
        S_WGT_WAIT: if (stat_i.done) state_q <= S_IDLE;
        S_ST1: begin
          if (in1) state_q <= seed1_now ? S_SEED1 : S_ST2;
          else     state_q <= S_W1;
        end
        S_SEED1: state_q <= S_W1;
        S_W1:    if (stat_i.done) state_q <= S_ST2;
        S_ST2: begin
          if (in2 && j_lt) state_q <= seed2_now ? S_SEED2 : S_END;
          else if (in2)    state_q <= S_W2;
          else             state_q <= S_END;
        end
        S_SEED2: state_q <= S_W2;
        S_W2:    if (stat_i.done) state_q <= S_END;
        S_END: begin
          if (bar_q != BAR_MAX) bar_q <= bar_q + 1'b1;
          state_q <= emit ? S_WF : S_IDLE;
        end
        S_WF:  if (stat_i.done) state_q <= S_PUB;
        S_PUB: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.done |-> (state_q == S_WGT_WAIT || state_q == S_W1 ||
                     state_q == S_W2 || state_q == S_WF))
    else $error("lane finished outside a wait state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && primed_q && !wt_pend_q) |=> state_q == S_ST1)
    else $error("accepted price did not start processing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || m_ready_i))
    else $error("result overwrote a word not yet taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bar_q >= $past(bar_q))
    else $error("bar count went backwards");

endmodule

// File: rtl/true_strength_index.sv
// True strength index over a stream of unsigned Q16.16 close prices. The
// first price after reset only primes the previous price; each later price
// feeds its momentum and its magnitude through two cascaded EMA stages, and
// once both warm-ups are over every price gives one signed Q7.16 result,
// clamped to +-100. Work is done by two serial lanes (one per chain) that
// multiply or divide one bit per cycle, so the per-price time is set by
// those lanes: in steady state two 24-step multiplies and a 23-step final
// divide, on the bars where a stage is seeded a 43-step mean division, on
// warm-up bars the first EMA only, and on bars that only add to a seed no
// lane work at all. After reset and after every register write the weights
// 2/(N+1) are recomputed by a 25-step division in which no price is taken.
// One result word is held on the output; while it waits the next price is
// still taken and worked on, but its result and any price after it wait
// until the held word is taken.
module true_strength_index (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tsi_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [tsi_pkg::PER_W-1:0]   cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [tsi_pkg::PRICE_W-1:0] s_axis_tdata,   // [31:0] price
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tsi_pkg::OUT_W-1:0]   m_axis_tdata    // [23:0] tsi_value
);
  import tsi_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tsi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  tsi_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .price_i    (s_axis_tdata),
    .tsi_value_o(m_axis_tdata),
    .rst_ni     (rst_ni)
  );

endmodule
